// File: hdl/aoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared types and constants for the box overlap and contact pipeline.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int COORD_W = 32;   // width of every coordinate field
    localparam int DIST_W  = 33;   // width of the distance result
    localparam int NUM_AXES = 3;

    typedef logic [1:0] t_axis;

    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    // result fields that ride alongside the distance computation
    typedef struct packed {
        logic                      hit;
        t_axis                     normal_axis;
        logic                      normal_negative;
        logic signed [COORD_W-1:0] contact_x;
        logic signed [COORD_W-1:0] contact_y;
        logic signed [COORD_W-1:0] contact_z;
    } t_side;

endpackage

// File: hdl/aoc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_box_if / aoc_res_if
// Valid/ready channels for box pairs in and overlap results out.
// ----------------------------------------------------------------------------
interface aoc_box_if;
    logic                                valid;
    logic                                ready;
    logic signed [aoc_pkg::COORD_W-1:0]  a_min_x;
    logic signed [aoc_pkg::COORD_W-1:0]  a_min_y;
    logic signed [aoc_pkg::COORD_W-1:0]  a_min_z;
    logic signed [aoc_pkg::COORD_W-1:0]  a_max_x;
    logic signed [aoc_pkg::COORD_W-1:0]  a_max_y;
    logic signed [aoc_pkg::COORD_W-1:0]  a_max_z;
    logic signed [aoc_pkg::COORD_W-1:0]  b_min_x;
    logic signed [aoc_pkg::COORD_W-1:0]  b_min_y;
    logic signed [aoc_pkg::COORD_W-1:0]  b_min_z;
    logic signed [aoc_pkg::COORD_W-1:0]  b_max_x;
    logic signed [aoc_pkg::COORD_W-1:0]  b_max_y;
    logic signed [aoc_pkg::COORD_W-1:0]  b_max_z;

    modport source (
        output valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
               b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
        input  ready
    );
    modport sink (
        input  valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
               b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
        output ready
    );
endinterface

interface aoc_res_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [aoc_pkg::DIST_W-1:0]          distance;
    logic [1:0]                          normal_axis;
    logic                                normal_negative;
    logic signed [aoc_pkg::COORD_W-1:0]  contact_x;
    logic signed [aoc_pkg::COORD_W-1:0]  contact_y;
    logic signed [aoc_pkg::COORD_W-1:0]  contact_z;

    modport source (
        output valid, hit, distance, normal_axis, normal_negative,
               contact_x, contact_y, contact_z,
        input  ready
    );
    modport sink (
        input  valid, hit, distance, normal_axis, normal_negative,
               contact_x, contact_y, contact_z,
        output ready
    );
endinterface

// File: hdl/aoc_sep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_sep
// Two stages: separation vector, contact midpoints and center order, then
// magnitudes, hit flag and normal axis selection.
// ----------------------------------------------------------------------------
module aoc_sep #(
    parameter int COORD_BITS = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic [2:0][aoc_pkg::COORD_W-1:0]         i_a_min,
    input  logic [2:0][aoc_pkg::COORD_W-1:0]         i_a_max,
    input  logic [2:0][aoc_pkg::COORD_W-1:0]         i_b_min,
    input  logic [2:0][aoc_pkg::COORD_W-1:0]         i_b_max,
    output logic                                     o_valid,
    output logic [2:0][COORD_BITS-1:0]               o_mag,
    output aoc_pkg::t_side                           o_side
);

    localparam int CB = COORD_BITS;

    // stage 1
    logic signed [CB:0]                    n_sep     [aoc_pkg::NUM_AXES];
    logic signed [CB:0]                    r_sep     [aoc_pkg::NUM_AXES];
    logic signed [aoc_pkg::COORD_W-1:0]    n_contact [aoc_pkg::NUM_AXES];
    logic signed [aoc_pkg::COORD_W-1:0]    r_contact [aoc_pkg::NUM_AXES];
    logic [2:0]                            n_neg;
    logic [2:0]                            r_neg;
    logic                                  r_valid1;

    // stage 2
    logic [2:0][CB-1:0]                    n_mag;
    logic [2:0][CB-1:0]                    r_mag;
    aoc_pkg::t_side                        n_side;
    aoc_pkg::t_side                        r_side;
    logic                                  r_valid2;

    always_comb begin
        logic signed [CB-1:0] amin, amax, bmin, bmax, lo, hi;
        logic signed [CB:0]   d1, d2, mid_sum, ctr_a, ctr_b;
        for (int i = 0; i < aoc_pkg::NUM_AXES; i++) begin
            // bits above the coordinate width are dropped
            amin = signed'(i_a_min[i][CB-1:0]);
            amax = signed'(i_a_max[i][CB-1:0]);
            bmin = signed'(i_b_min[i][CB-1:0]);
            bmax = signed'(i_b_max[i][CB-1:0]);

            d1 = (CB+1)'(bmin) - (CB+1)'(amax);
            d2 = (CB+1)'(amin) - (CB+1)'(bmax);
            n_sep[i] = (d1 > d2) ? d1 : d2;

            ctr_a = (CB+1)'(amin) + (CB+1)'(amax);
            ctr_b = (CB+1)'(bmin) + (CB+1)'(bmax);
            n_neg[i] = (ctr_b < ctr_a);

            lo = (amin > bmin) ? amin : bmin;
            hi = (amax < bmax) ? amax : bmax;
            mid_sum = (CB+1)'(lo) + (CB+1)'(hi);
            // drop the low bit: floor halving of the signed sum
            n_contact[i] = aoc_pkg::COORD_W'(signed'(mid_sum[CB:1]));
        end
    end

    always_comb begin
        logic signed [CB:0] mag_full;
        logic signed [CB:0] best;
        logic [2:0]         pos;
        for (int i = 0; i < aoc_pkg::NUM_AXES; i++) begin
            mag_full = r_sep[i][CB] ? -r_sep[i] : r_sep[i];
            n_mag[i] = mag_full[CB-1:0];
            pos[i]   = !r_sep[i][CB] && (r_sep[i] != '0);
        end

        n_side.normal_axis = aoc_pkg::AXIS_X;
        best = r_sep[0];
        if (r_sep[1] > best) begin
            n_side.normal_axis = aoc_pkg::AXIS_Y;
            best = r_sep[1];
        end
        if (r_sep[2] > best) begin
            n_side.normal_axis = aoc_pkg::AXIS_Z;
        end

        case (n_side.normal_axis)
            aoc_pkg::AXIS_X: n_side.normal_negative = r_neg[0];
            aoc_pkg::AXIS_Y: n_side.normal_negative = r_neg[1];
            aoc_pkg::AXIS_Z: n_side.normal_negative = r_neg[2];
            default:         n_side.normal_negative = 1'b0;
        endcase

        n_side.hit       = ~|pos;
        n_side.contact_x = r_contact[0];
        n_side.contact_y = r_contact[1];
        n_side.contact_z = r_contact[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sep     <= n_sep;
            r_contact <= n_contact;
            r_neg     <= n_neg;
            r_mag     <= n_mag;
            r_side    <= n_side;
        end
    end

    assign o_valid = r_valid2;
    assign o_mag   = r_mag;
    assign o_side  = r_side;

endmodule

// File: hdl/aoc_sumsq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_sumsq
// Two stages: square each separation magnitude, then add the three squares.
// ----------------------------------------------------------------------------
module aoc_sumsq #(
    parameter int COORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [2:0][COORD_BITS-1:0]    i_mag,
    input  aoc_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [2*COORD_BITS+1:0]       o_sum,
    output aoc_pkg::t_side                o_side
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;

    logic [2:0][SQ_W-1:0]   r_sq;
    logic [SUM_W-1:0]       r_sum;
    aoc_pkg::t_side         r_side1;
    aoc_pkg::t_side         r_side2;
    logic                   r_valid1;
    logic                   r_valid2;
    logic [SUM_W-1:0]       n_sum;

    assign n_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < aoc_pkg::NUM_AXES; i++) begin
                r_sq[i] <= SQ_W'(i_mag[i]) * SQ_W'(i_mag[i]);
            end
            r_side1 <= i_side;
            r_sum   <= n_sum;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_valid2;
    assign o_sum   = r_sum;
    assign o_side  = r_side2;

endmodule

// File: hdl/aoc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_isqrt
// Pipelined floor square root, one root bit per stage, restoring method.
// ----------------------------------------------------------------------------
module aoc_isqrt #(
    parameter int ROOT_W = 33
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2*ROOT_W-1:0]    i_rad,
    input  aoc_pkg::t_side         i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output aoc_pkg::t_side         o_side
);

    localparam int REM_W = ROOT_W + 2;
    localparam int RAD_W = 2 * ROOT_W;

    logic [REM_W-1:0]     r_rem   [ROOT_W-1];
    logic [RAD_W-1:0]     r_rad   [ROOT_W-1];
    logic [ROOT_W-1:0]    r_root  [ROOT_W];
    aoc_pkg::t_side       r_side  [ROOT_W];
    logic [ROOT_W-1:0]    r_valid;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W-1:0]   w_rem;
        logic [RAD_W-1:0]   w_rad;
        logic [ROOT_W-1:0]  w_root;
        aoc_pkg::t_side     w_side;
        logic               w_valid;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        logic               take;
        logic [REM_W-1:0]   n_rem;
        logic [ROOT_W-1:0]  n_root;

        if (g == 0) begin : g_first
            assign w_rem   = '0;
            assign w_rad   = i_rad;
            assign w_root  = '0;
            assign w_side  = i_side;
            assign w_valid = i_valid;
        end else begin : g_next
            assign w_rem   = r_rem[g-1];
            assign w_rad   = r_rad[g-1];
            assign w_root  = r_root[g-1];
            assign w_side  = r_side[g-1];
            assign w_valid = r_valid[g-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_sh = {w_rem[ROOT_W-1:0], w_rad[RAD_W-1 -: 2]};
        assign trial  = {w_root, 2'b01};
        assign take   = (rem_sh >= trial);
        assign n_rem  = take ? (rem_sh - trial) : rem_sh;
        assign n_root = {w_root[ROOT_W-2:0], take};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[g] <= n_root;
                r_side[g] <= w_side;
            end
        end

        if (g < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_rad[g] <= {w_rad[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// File: hdl/aabb_overlap_contact.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_contact
// Overlap test, separation distance, normal and contact point for box pairs.
// ----------------------------------------------------------------------------
// One box pair is taken per clock and one result leaves per clock while the
// output is not stalled. From the input transfer to the result on the output,
// two stages form the separation vector and pick the normal, two stages square
// and sum, and the square root resolves one bit per stage over COORD_BITS + 1
// stages, the last of which is the output register. The whole pipeline
// advances together; it halts only while a finished result sits on the output
// without being taken, and then input ready drops in the same cycle.
module aabb_overlap_contact #(
    parameter int COORD_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aoc_box_if.sink    i_box,
    aoc_res_if.source  o_res
);

    localparam int ROOT_W = COORD_BITS + 1;

    logic                                    w_en;
    logic [2:0][aoc_pkg::COORD_W-1:0]        w_a_min;
    logic [2:0][aoc_pkg::COORD_W-1:0]        w_a_max;
    logic [2:0][aoc_pkg::COORD_W-1:0]        w_b_min;
    logic [2:0][aoc_pkg::COORD_W-1:0]        w_b_max;
    logic                                    w_sep_valid;
    logic [2:0][COORD_BITS-1:0]              w_mag;
    aoc_pkg::t_side                          w_sep_side;
    logic                                    w_sum_valid;
    logic [2*ROOT_W-1:0]                     w_sum;
    aoc_pkg::t_side                          w_sum_side;
    logic                                    w_out_valid;
    logic [ROOT_W-1:0]                       w_root;
    aoc_pkg::t_side                          w_out_side;

    // advance everything unless the output holds a result nobody takes
    assign w_en        = !w_out_valid || o_res.ready;
    assign i_box.ready = w_en;

    assign w_a_min = {i_box.a_min_z, i_box.a_min_y, i_box.a_min_x};
    assign w_a_max = {i_box.a_max_z, i_box.a_max_y, i_box.a_max_x};
    assign w_b_min = {i_box.b_min_z, i_box.b_min_y, i_box.b_min_x};
    assign w_b_max = {i_box.b_max_z, i_box.b_max_y, i_box.b_max_x};

    aoc_sep #(
        .COORD_BITS (COORD_BITS)
    ) u_sep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_box.valid),
        .i_a_min (w_a_min),
        .i_a_max (w_a_max),
        .i_b_min (w_b_min),
        .i_b_max (w_b_max),
        .o_valid (w_sep_valid),
        .o_mag   (w_mag),
        .o_side  (w_sep_side)
    );

    aoc_sumsq #(
        .COORD_BITS (COORD_BITS)
    ) u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sep_valid),
        .i_mag   (w_mag),
        .i_side  (w_sep_side),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum),
        .o_side  (w_sum_side)
    );

    aoc_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_valid),
        .i_rad   (w_sum),
        .i_side  (w_sum_side),
        .o_valid (w_out_valid),
        .o_root  (w_root),
        .o_side  (w_out_side)
    );

    assign o_res.valid           = w_out_valid;
    assign o_res.hit             = w_out_side.hit;
    assign o_res.distance        = aoc_pkg::DIST_W'(w_root);
    assign o_res.normal_axis     = w_out_side.normal_axis;
    assign o_res.normal_negative = w_out_side.normal_negative;
    assign o_res.contact_x       = w_out_side.contact_x;
    assign o_res.contact_y       = w_out_side.contact_y;
    assign o_res.contact_z       = w_out_side.contact_z;

    // the normal always names one of the three axes
    a_axis_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.normal_axis <= aoc_pkg::AXIS_Z)
        else $error("normal axis out of range");

    // a positive separation component is at least one LSB long
    a_miss_has_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.distance != '0)
        else $error("miss result with zero distance");

    // a held result must freeze the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_box.ready)
        else $error("input ready while output stalled");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box overlap and contact pipeline. Box pairs are
// streamed in over the valid/ready channel: first a directed set (touching,
// separated on each axis, full-scale extremes, inverted boxes, odd midpoints,
// normal ties), then random pairs, mostly well-formed and near each other.
// Every accepted pair is predicted in order. Every result transfer is checked
// field by field. Both sides idle in random bursts, and the result side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     COORD_BITS = 32;
    localparam longint ONE        = 65536;          // 1.0 in Q16.16
    localparam longint MINV       = -64'sd2147483648;
    localparam longint MAXV       = 2147483647;
    localparam int     NUM_RANDOM = 400;

    typedef struct {
        logic signed [aoc_pkg::COORD_W-1:0] a_min [aoc_pkg::NUM_AXES];
        logic signed [aoc_pkg::COORD_W-1:0] a_max [aoc_pkg::NUM_AXES];
        logic signed [aoc_pkg::COORD_W-1:0] b_min [aoc_pkg::NUM_AXES];
        logic signed [aoc_pkg::COORD_W-1:0] b_max [aoc_pkg::NUM_AXES];
    } t_box_pair;

    typedef struct {
        logic                               hit;
        logic [aoc_pkg::DIST_W-1:0]         distance;
        aoc_pkg::t_axis                     normal_axis;
        logic                               normal_negative;
        logic signed [aoc_pkg::COORD_W-1:0] contact [aoc_pkg::NUM_AXES];
    } t_contact;

    class contact_scoreboard;
        t_contact    pending_contacts[$];
        int unsigned fail_count = 0;

        function longint widen(logic [aoc_pkg::COORD_W-1:0] v);
            return longint'($signed(v[COORD_BITS-1:0]));
        endfunction

        function t_contact predict_contact(t_box_pair p);
            longint         amn [aoc_pkg::NUM_AXES];
            longint         amx [aoc_pkg::NUM_AXES];
            longint         bmn [aoc_pkg::NUM_AXES];
            longint         bmx [aoc_pkg::NUM_AXES];
            longint         sep [aoc_pkg::NUM_AXES];
            longint         lo, hi, mid;
            logic [71:0]    mag, sumsq, trial, root;
            aoc_pkg::t_axis ax;
            t_contact       r;
            r.hit = 1'b1;
            sumsq = '0;
            root  = '0;
            ax    = aoc_pkg::AXIS_X;
            for (int i = 0; i < aoc_pkg::NUM_AXES; i++) begin
                amn[i] = widen(p.a_min[i]);
                amx[i] = widen(p.a_max[i]);
                bmn[i] = widen(p.b_min[i]);
                bmx[i] = widen(p.b_max[i]);
                sep[i] = (bmn[i] - amx[i] > amn[i] - bmx[i]) ? bmn[i] - amx[i]
                                                             : amn[i] - bmx[i];
                if (sep[i] > 0) r.hit = 1'b0;
                mag   = (sep[i] < 0) ? -sep[i] : sep[i];
                sumsq = sumsq + mag * mag;
            end
            // floor square root, one bit at a time from the top
            for (int b = 34; b >= 0; b--) begin
                trial = root | (72'd1 << b);
                if (trial * trial <= sumsq) root = trial;
            end
            r.distance = root[aoc_pkg::DIST_W-1:0];
            for (int i = 1; i < aoc_pkg::NUM_AXES; i++)
                if (sep[i] > sep[ax]) ax = aoc_pkg::t_axis'(i);
            r.normal_axis     = ax;
            r.normal_negative = (bmn[ax] + bmx[ax]) < (amn[ax] + amx[ax]);
            for (int i = 0; i < aoc_pkg::NUM_AXES; i++) begin
                lo  = (amn[i] > bmn[i]) ? amn[i] : bmn[i];
                hi  = (amx[i] < bmx[i]) ? amx[i] : bmx[i];
                mid = (lo + hi) >>> 1;
                r.contact[i] = mid[aoc_pkg::COORD_W-1:0];
            end
            return r;
        endfunction

        function void note_pair(t_box_pair p);
            pending_contacts.push_back(predict_contact(p));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_contact(t_contact got);
            t_contact want;
            if (pending_contacts.size() == 0) begin
                $error("result transfer with no box pair outstanding");
                fail_count++;
                return;
            end
            want = pending_contacts.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("distance", want.distance, got.distance);
            compare_field("normal_axis", want.normal_axis, got.normal_axis);
            compare_field("normal_negative", want.normal_negative, got.normal_negative);
            compare_field("contact_x", want.contact[0], got.contact[0]);
            compare_field("contact_y", want.contact[1], got.contact[1]);
            compare_field("contact_z", want.contact[2], got.contact[2]);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    aoc_box_if box_ch ();
    aoc_res_if res_ch ();

    aabb_overlap_contact #(
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch),
        .o_res   (res_ch)
    );

    contact_scoreboard sb = new();

    int hold_cnt  = 0;      // result-side hold-off, counted down by the receiver
    bit calm_tail = 1'b0;   // no idling on either side
    int gap_pct   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_box_pair uniform_pair(longint alo, longint ahi,
                                               longint blo, longint bhi);
        t_box_pair p;
        for (int i = 0; i < aoc_pkg::NUM_AXES; i++) begin
            p.a_min[i] = alo;
            p.a_max[i] = ahi;
            p.b_min[i] = blo;
            p.b_max[i] = bhi;
        end
        return p;
    endfunction

    function automatic t_box_pair random_pair();
        t_box_pair p;
        int        kind;
        longint    span, c, off, u, v;
        kind = $urandom_range(0, 9);
        span = longint'(1) << $urandom_range(2, 28);
        for (int i = 0; i < aoc_pkg::NUM_AXES; i++) begin
            if (kind == 5) begin
                // shared center
                c          = longint'($urandom_range(0, 2 * span)) - span;
                u          = $urandom_range(0, span);
                v          = $urandom_range(0, span);
                p.a_min[i] = c - u;
                p.a_max[i] = c + u;
                p.b_min[i] = c - v;
                p.b_max[i] = c + v;
            end else if (kind < 6) begin
                c          = longint'($urandom_range(0, 2 * span)) - span;
                off        = longint'($urandom_range(0, 4 * span)) - 2 * span;
                p.a_min[i] = c - $urandom_range(0, span);
                p.a_max[i] = c + $urandom_range(0, span);
                p.b_min[i] = c + off - $urandom_range(0, span);
                p.b_max[i] = c + off + $urandom_range(0, span);
            end else if (kind < 8) begin
                u          = longint'($signed($urandom()));
                v          = longint'($signed($urandom()));
                p.a_min[i] = (u < v) ? u : v;
                p.a_max[i] = (u < v) ? v : u;
                u          = longint'($signed($urandom()));
                v          = longint'($signed($urandom()));
                p.b_min[i] = (u < v) ? u : v;
                p.b_max[i] = (u < v) ? v : u;
            end else begin
                p.a_min[i] = $urandom();
                p.a_max[i] = $urandom();
                p.b_min[i] = $urandom();
                p.b_max[i] = $urandom();
            end
        end
        // copy y onto z now and then to provoke normal ties
        if (kind < 6 && $urandom_range(0, 7) == 0) begin
            p.a_min[2] = p.a_min[1];
            p.a_max[2] = p.a_max[1];
            p.b_min[2] = p.b_min[1];
            p.b_max[2] = p.b_max[1];
        end
        return p;
    endfunction

    task automatic offer_pair(input t_box_pair p);
        box_ch.a_min_x <= p.a_min[0];
        box_ch.a_min_y <= p.a_min[1];
        box_ch.a_min_z <= p.a_min[2];
        box_ch.a_max_x <= p.a_max[0];
        box_ch.a_max_y <= p.a_max[1];
        box_ch.a_max_z <= p.a_max[2];
        box_ch.b_min_x <= p.b_min[0];
        box_ch.b_min_y <= p.b_min[1];
        box_ch.b_min_z <= p.b_min[2];
        box_ch.b_max_x <= p.b_max[0];
        box_ch.b_max_y <= p.b_max[1];
        box_ch.b_max_z <= p.b_max[2];
        box_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!box_ch.ready);
        sb.note_pair(p);
        // keep offering back to back while the result side holds off
        if (!calm_tail && hold_cnt == 0 && $urandom_range(0, 99) < gap_pct) begin
            box_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        t_box_pair p;
        gap_pct = 20;
        // identical boxes: equal centers, all axes tied
        offer_pair(uniform_pair(0, ONE, 0, ONE));
        // faces touching on every axis
        offer_pair(uniform_pair(0, ONE, ONE, 2 * ONE));
        // partial overlap, B below
        offer_pair(uniform_pair(0, ONE, -ONE / 2, ONE / 2));
        // separated along x only
        p = uniform_pair(0, 2 * ONE, 0, 2 * ONE);
        p.b_min[0] = 3 * ONE;
        p.b_max[0] = 4 * ONE;
        offer_pair(p);
        // separated along y, B below
        p = uniform_pair(0, 2 * ONE, 0, 2 * ONE);
        p.b_min[1] = -5 * ONE;
        p.b_max[1] = -3 * ONE;
        offer_pair(p);
        // separated along z
        p = uniform_pair(0, 2 * ONE, 0, 2 * ONE);
        p.b_min[2] = 7 * ONE;
        p.b_max[2] = 9 * ONE;
        offer_pair(p);
        // separated by three units on x and four on y, overlapping on z
        p = uniform_pair(0, ONE, 0, ONE);
        p.b_min[0] = 4 * ONE;
        p.b_max[0] = 5 * ONE;
        p.b_min[1] = 5 * ONE;
        p.b_max[1] = 6 * ONE;
        offer_pair(p);
        // y and z separated by the same amount
        p = uniform_pair(0, ONE, 0, ONE);
        p.b_min[1] = 3 * ONE;
        p.b_max[1] = 4 * ONE;
        p.b_min[2] = 3 * ONE;
        p.b_max[2] = 4 * ONE;
        offer_pair(p);
        // shallowest penetration on z with B below
        p = uniform_pair(0, 4 * ONE, 0, 4 * ONE);
        p.b_min[0] = 3 * ONE;
        p.b_max[0] = 5 * ONE;
        p.b_min[1] = ONE;
        p.b_max[1] = 3 * ONE;
        p.b_min[2] = -3 * ONE;
        p.b_max[2] = ONE / 2;
        offer_pair(p);
        // full-scale extremes, largest distance both ways
        offer_pair(uniform_pair(MINV, MINV, MAXV, MAXV));
        offer_pair(uniform_pair(MAXV, MAXV, MINV, MINV));
        offer_pair(uniform_pair(MINV, MAXV, MINV, MAXV));
        offer_pair(uniform_pair(MAXV, MINV, MAXV, MINV));
        offer_pair(uniform_pair(MINV, MAXV, MAXV, MINV));
        // all ones against all zeros
        offer_pair(uniform_pair(-1, -1, 0, 0));
        offer_pair(uniform_pair(0, 0, -1, -1));
        // A inverted
        offer_pair(uniform_pair(3 * ONE, -ONE, 0, ONE));
        // odd midpoint sums, negative and positive
        offer_pair(uniform_pair(-5, -1, -4, 2));
        offer_pair(uniform_pair(1, 5, 2, 8));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        box_ch.valid   <= 1'b0;
        box_ch.a_min_x <= '0;
        box_ch.a_min_y <= '0;
        box_ch.a_min_z <= '0;
        box_ch.a_max_x <= '0;
        box_ch.a_max_y <= '0;
        box_ch.a_max_z <= '0;
        box_ch.b_min_x <= '0;
        box_ch.b_min_y <= '0;
        box_ch.b_min_z <= '0;
        box_ch.b_max_x <= '0;
        box_ch.b_max_y <= '0;
        box_ch.b_max_z <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 50 == 0) gap_pct = $urandom_range(0, 3) * 10;
            if (n == 150) hold_cnt = 300;
            if (n == NUM_RANDOM - 40) calm_tail = 1'b1;
            offer_pair(random_pair());
        end
        box_ch.valid <= 1'b0;

        while (sb.pending_contacts.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, calm windows and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int stall_cnt = 0;
        int window    = 0;
        int stall_pct = 0;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (window == 0) begin
                window    = $urandom_range(40, 160);
                stall_pct = $urandom_range(0, 3) * 8;
            end
            window--;
            if (hold_cnt > 0) begin
                res_ch.ready <= 1'b0;
                hold_cnt--;
            end else if (stall_cnt > 0) begin
                res_ch.ready <= 1'b0;
                stall_cnt--;
            end else begin
                res_ch.ready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 99) < stall_pct)
                    stall_cnt = $urandom_range(1, 17);
            end
        end
    end

    // check every result transfer
    always @(posedge i_clk) begin : take_result
        t_contact got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.hit             = res_ch.hit;
            got.distance        = res_ch.distance;
            got.normal_axis     = res_ch.normal_axis;
            got.normal_negative = res_ch.normal_negative;
            got.contact[0]      = res_ch.contact_x;
            got.contact[1]      = res_ch.contact_y;
            got.contact[2]      = res_ch.contact_z;
            sb.check_contact(got);
        end
    end

endmodule

// File: filelist.f
hdl/aoc_pkg.sv
hdl/aoc_if.sv
hdl/aoc_sep.sv
hdl/aoc_sumsq.sv
hdl/aoc_isqrt.sv
hdl/aabb_overlap_contact.sv
tb/sv/tb_top.sv
